// ===== hdl/morse_two_bit_packer_defines.svh =====
// Assertion macros shared by the Morse two-bit packer modules.
// Each takes label, clock, reset, antecedent, consequent and message string.
`ifndef MORSE_TWO_BIT_PACKER_DEFINES_SVH
`define MORSE_TWO_BIT_PACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTBP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mtbp_pkg.sv =====
// Package for the Morse two-bit packer: widths, symbol codes, result types
// and the Morse code table. No dependencies.
package mtbp_pkg;

   localparam int WORD_BITS = 64;
   localparam int SYM_PER_WORD = WORD_BITS / 2;
   localparam int CNT_W = $clog2(SYM_PER_WORD);
   localparam int TOTAL_W = CNT_W + 1;
   localparam int LETTER_W = 5;
   localparam int NUM_LETTERS = 26;
   localparam int MAX_CODE_LEN = 4;
   localparam int LEN_W = 3;
   localparam int SYM_FIELD_W = 2 * (MAX_CODE_LEN + 1);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   localparam logic [1:0] SYM_DOT = 2'b00;
   localparam logic [1:0] SYM_DASH = 2'b01;
   localparam logic [1:0] SYM_SPACE = 2'b10;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [MAX_CODE_LEN-1:0] pat;
   } morse_code_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic last_word;
   } result_type;

   typedef struct packed {
      logic [1:0] valid;
      result_type item0;
      result_type item1;
   } push_type;

   // Pattern holds the first symbol in bit len-1; a one is a dash.
   function automatic morse_code_type morse_lookup(logic [LETTER_W-1:0] letter);
      morse_code_type code;
      case (letter)
         5'd0: code = '{3'd2, 4'h1};
         5'd1: code = '{3'd4, 4'h8};
         5'd2: code = '{3'd4, 4'hA};
         5'd3: code = '{3'd3, 4'h4};
         5'd4: code = '{3'd1, 4'h0};
         5'd5: code = '{3'd4, 4'h2};
         5'd6: code = '{3'd3, 4'h6};
         5'd7: code = '{3'd4, 4'h0};
         5'd8: code = '{3'd2, 4'h0};
         5'd9: code = '{3'd4, 4'h7};
         5'd10: code = '{3'd3, 4'h5};
         5'd11: code = '{3'd4, 4'h4};
         5'd12: code = '{3'd2, 4'h3};
         5'd13: code = '{3'd2, 4'h2};
         5'd14: code = '{3'd3, 4'h7};
         5'd15: code = '{3'd4, 4'h6};
         5'd16: code = '{3'd4, 4'hD};
         5'd17: code = '{3'd3, 4'h2};
         5'd18: code = '{3'd3, 4'h0};
         5'd19: code = '{3'd1, 4'h1};
         5'd20: code = '{3'd3, 4'h1};
         5'd21: code = '{3'd4, 4'h1};
         5'd22: code = '{3'd3, 4'h3};
         5'd23: code = '{3'd4, 4'h9};
         5'd24: code = '{3'd4, 4'hB};
         5'd25: code = '{3'd4, 4'hC};
         default: code = '{3'd0, 4'h0};
      endcase
      return code;
   endfunction

   // Symbols of one letter, first symbol in the top two bits, followed by
   // the letter space unless the letter ends the message.
   function automatic logic [SYM_FIELD_W-1:0] symbol_field(morse_code_type code,
                                                         logic last);
      logic [SYM_FIELD_W-1:0] field;
      logic [1:0] bit_idx;
      field = '0;
      for (int i = 0; i <= MAX_CODE_LEN; i++) begin
         bit_idx = 2'(code.len - LEN_W'(i) - LEN_W'(1));
         if (LEN_W'(i) < code.len) begin
            field[SYM_FIELD_W-1-2*i -: 2] = code.pat[bit_idx] ? SYM_DASH : SYM_DOT;
         end else if (LEN_W'(i) == code.len && !last) begin
            field[SYM_FIELD_W-1-2*i -: 2] = SYM_SPACE;
         end
      end
      return field;
   endfunction

endpackage

// ===== hdl/mtbp_if.sv =====
// Handshake interfaces for the letter input and the packed word output.
// Depends on mtbp_pkg.
interface mtbp_req_if
   import mtbp_pkg::*;
;
   logic valid;
   logic ready;
   logic [LETTER_W-1:0] letter;
   logic last_letter;

   modport source (output valid, output letter, output last_letter, input ready);
   modport sink (input valid, input letter, input last_letter, output ready);
endinterface

interface mtbp_rsp_if
   import mtbp_pkg::*;
;
   logic valid;
   logic ready;
   logic [WORD_BITS-1:0] word;
   logic last_word;

   modport source (output valid, output word, output last_word, input ready);
   modport sink (input valid, input word, input last_word, output ready);
endinterface

// ===== hdl/morse_two_bit_packer.sv =====
// Top level of the Morse two-bit packer: letter packing stage and result queue.
// Depends on mtbp_pkg, mtbp_if, mtbp_pack and mtbp_fifo.
//
//   Channel  Dir  Payload                 Accepted when
//   req_if   in   letter[4:0], last_letter valid && ready
//   rsp_if   out  word[63:0], last_word   valid && ready
//
// One letter enters per cycle unless the input stalls; its words are pushed from the letter register.
// The single output port hands out one word per cycle while rsp_if.ready is high.
// Input stalls only when the four-entry result queue has fewer than two free slots.
// Reset is synchronous and clears the open word, symbol count and queue.

module morse_two_bit_packer
   import mtbp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mtbp_req_if.sink req_if,
   mtbp_rsp_if.source rsp_if
);

   push_type push;
   logic room;

   mtbp_pack u_pack (
      .clock (clock),
      .reset (reset),
      .room (room),
      .push (push),
      .req_if (req_if)
   );

   mtbp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push (push),
      .room (room),
      .rsp_if (rsp_if)
   );

endmodule

// ===== hdl/mtbp_fifo.sv =====
// Result queue: takes up to two packed words per cycle, hands out one while rsp_if.ready is high.
// Depends on mtbp_pkg, mtbp_rsp_if and the assertion macro header.
`include "morse_two_bit_packer_defines.svh"

module mtbp_fifo
   import mtbp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  push_type push,
   output logic room,
   mtbp_rsp_if.source rsp_if
);

   result_type mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_CNT_W-1:0] push_n;
   logic pop;

   assign pop = rsp_if.valid && rsp_if.ready;
   assign push_n = FIFO_CNT_W'(push.valid[0]) + FIFO_CNT_W'(push.valid[1]);
   assign room = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);

   assign rsp_if.valid = count_ff != '0;
   assign rsp_if.word = mem[rd_ptr_ff].word;
   assign rsp_if.last_word = mem[rd_ptr_ff].last_word;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[FIFO_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in = count_ff + push_n - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid[0]) begin
         mem[wr_ptr_ff] <= push.item0;
      end
      if (push.valid[1]) begin
         mem[wr_ptr_ff + FIFO_PTR_W'(1)] <= push.item1;
      end
   end

   `MTBP_ASSERT_SAME(a_fifo_no_overflow, clock, reset, push.valid[0],
                     count_ff + push_n <= FIFO_CNT_W'(FIFO_DEPTH),
                     "result queue written beyond its depth")
   `MTBP_ASSERT_NEXT(a_fifo_pop_only, clock, reset, pop && !push.valid[0],
                     count_ff == $past(count_ff) - FIFO_CNT_W'(1),
                     "result queue count wrong after a pop")
   `MTBP_ASSERT_NEXT(a_fifo_hold_word, clock, reset, rsp_if.valid && !rsp_if.ready,
                     rsp_if.valid && $stable(rsp_if.word),
                     "waiting word changed before it was taken")

endmodule

// ===== hdl/mtbp_pack.sv =====
// Letter register, Morse lookup and symbol packing into the open word.
// Depends on mtbp_pkg, mtbp_req_if and the assertion macro header.
`include "morse_two_bit_packer_defines.svh"

module mtbp_pack
   import mtbp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic room,
   output push_type push,
   mtbp_req_if.sink req_if
);

   logic in_valid_ff, in_valid_in;
   logic [LETTER_W-1:0] letter_ff;
   logic last_ff;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] count_ff, count_in;

   morse_code_type code;
   logic [SYM_FIELD_W-1:0] field;
   logic [LEN_W-1:0] sym_n;
   logic [TOTAL_W-1:0] total;
   logic [TOTAL_W-1:0] shift_amt;
   logic [2*WORD_BITS-1:0] ext;
   logic full;
   logic [WORD_BITS-1:0] next_acc;
   logic [CNT_W-1:0] next_cnt;
   logic [WORD_BITS-1:0] final_word;
   logic final_push;
   logic advance;

   assign advance = in_valid_ff && room;
   assign req_if.ready = !in_valid_ff || room;
   assign in_valid_in = req_if.ready ? req_if.valid : in_valid_ff;

   always_comb begin
      code = morse_lookup(letter_ff);
      field = symbol_field(code, last_ff);
      sym_n = code.len + LEN_W'(!last_ff);
      total = TOTAL_W'(count_ff) + TOTAL_W'(sym_n);
      shift_amt = {count_ff, 1'b0};
      ext = {acc_ff, {WORD_BITS{1'b0}}}
            | ({field, {(2*WORD_BITS-SYM_FIELD_W){1'b0}}} >> shift_amt);
      full = total >= TOTAL_W'(SYM_PER_WORD);
      next_acc = full ? ext[WORD_BITS-1:0] : ext[2*WORD_BITS-1:WORD_BITS];
      next_cnt = full ? CNT_W'(total - TOTAL_W'(SYM_PER_WORD)) : CNT_W'(total);
      final_word = next_acc | ({WORD_BITS{1'b1}} >> {next_cnt, 1'b0});
      final_push = last_ff && !(full && next_cnt == '0);

      push.valid[0] = advance && (full || final_push);
      push.valid[1] = advance && full && final_push;
      push.item0.word = full ? ext[2*WORD_BITS-1:WORD_BITS] : final_word;
      push.item0.last_word = full ? (last_ff && next_cnt == '0) : 1'b1;
      push.item1.word = final_word;
      push.item1.last_word = 1'b1;

      acc_in = acc_ff;
      count_in = count_ff;
      if (advance) begin
         acc_in = last_ff ? '0 : next_acc;
         count_in = last_ff ? '0 : next_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         acc_ff <= '0;
         count_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         acc_ff <= acc_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         letter_ff <= req_if.letter;
         last_ff <= req_if.last_letter;
      end
   end

   `MTBP_ASSERT_SAME(a_pack_second_after_first, clock, reset, push.valid[1],
                     push.valid[0] && !push.item0.last_word,
                     "second word pushed without a non-final first word")
   `MTBP_ASSERT_NEXT(a_pack_clear_after_last, clock, reset, advance && last_ff,
                     count_ff == '0 && acc_ff == '0,
                     "open word not cleared after the last letter")
   `MTBP_ASSERT_SAME(a_pack_hold_when_stalled, clock, reset, in_valid_ff && !room,
                     !req_if.ready && push.valid == 2'b00,
                     "letter register moved while the result queue is full")

endmodule
